FILE: sv/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Shared sizes and fixed-point constants for the Q15 direct-form FIR core.
// ----------------------------------------------------------------------------
package fir_pkg;

  // filter length and derived index width
  localparam int TAPS  = 61;
  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  // field widths
  localparam int DATA_W = 16;
  localparam int TAP_W  = 6;

  // product and accumulator widths (sum of TAPS full-scale products)
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS + 1) + 1;

  // rounding and scaling
  localparam int FRAC_BITS = 15;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32'h0000_4000);
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = ACC_W'(-32768);

  // item codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

endpackage

FILE: sv/fir_filter_q15_circular_core.sv
// ----------------------------------------------------------------------------
// fir_filter_q15_circular_core
// A sample transaction walks the delay line and coefficient memories one tap
// a cycle through the single multiply-accumulate, drains the read and multiply
// registers, and loads its rounded, saturated result into the output register
// once that register is free; a coefficient transaction completes on accept.
// No new transaction is taken until the last sample's result is loaded.
// Reset clears the control state and the per-entry valid bits, so both
// memories read as zero until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fir_filter_q15_circular_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic                                  op,
  input  logic signed [fir_pkg::DATA_W-1:0]     sample,
  input  logic        [fir_pkg::TAP_W-1:0]      tap,
  input  logic signed [fir_pkg::DATA_W-1:0]     coefficient,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic signed [fir_pkg::DATA_W-1:0]     filtered
);
  import fir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINAL
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

  state_t                    state;
  logic [IDX_W-1:0]          wp;
  logic [IDX_W-1:0]          age;
  logic [IDX_W-1:0]          pos;
  logic                      rd_vld;
  logic                      mul_vld;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  // memories and their per-entry valid bits
  logic signed [DATA_W-1:0]  dl_mem [TAPS];
  logic signed [DATA_W-1:0]  cf_mem [TAPS];
  logic [TAPS-1:0]           dl_valid;
  logic [TAPS-1:0]           cf_valid;

  // registered read data
  logic signed [DATA_W-1:0]  dl_rd;
  logic signed [DATA_W-1:0]  cf_rd;
  logic                      dl_rd_ok;
  logic                      cf_rd_ok;

  logic                      req_ok;
  logic                      smp_we;
  logic                      cf_we;
  logic [IDX_W-1:0]          wp_next;
  logic [IDX_W-1:0]          cf_wa;
  logic signed [DATA_W-1:0]  dl_op;
  logic signed [DATA_W-1:0]  cf_op;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [DATA_W-1:0]  sat;
  logic                      out_free;

  // transaction accept and write decode
  assign req_stall = (state != ST_IDLE);
  assign req_ok    = req_valid && !req_stall;
  assign wp_next   = (wp == LAST_IDX) ? '0 : wp + 1'b1;
  assign smp_we    = req_ok && (op == OP_SAMPLE);
  assign cf_we     = req_ok && (op == OP_COEF) && (32'(tap) < 32'(TAPS));
  assign cf_wa     = IDX_W'(tap);
  assign out_free  = !res_valid || !res_stall;

  // unwritten entries read as zero
  assign dl_op = dl_rd_ok ? dl_rd : '0;
  assign cf_op = cf_rd_ok ? cf_rd : '0;

  // round, floor shift and saturate
  assign rnd     = acc + ROUND_BIAS;
  assign shifted = rnd >>> FRAC_BITS;
  always_comb begin
    if (shifted > SAT_MAX) begin
      sat = SAT_MAX[DATA_W-1:0];
    end else if (shifted < SAT_MIN) begin
      sat = SAT_MIN[DATA_W-1:0];
    end else begin
      sat = shifted[DATA_W-1:0];
    end
  end

  // delay line memory
  always_ff @(posedge clk) begin
    if (smp_we) begin
      dl_mem[wp_next] <= sample;
    end
    dl_rd <= dl_mem[pos];
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cf_we) begin
      cf_mem[cf_wa] <= coefficient;
    end
    cf_rd <= cf_mem[age];
  end

  // valid bits, read alongside the memories
  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid <= '0;
      cf_valid <= '0;
      dl_rd_ok <= 1'b0;
      cf_rd_ok <= 1'b0;
    end else begin
      if (smp_we) begin
        dl_valid[wp_next] <= 1'b1;
      end
      if (cf_we) begin
        cf_valid[cf_wa] <= 1'b1;
      end
      dl_rd_ok <= dl_valid[pos];
      cf_rd_ok <= cf_valid[age];
    end
  end

  // sequencer, multiply-accumulate and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      age       <= '0;
      pos       <= '0;
      rd_vld    <= 1'b0;
      mul_vld   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_vld  <= (state == ST_RUN);
      mul_vld <= rd_vld;
      prod    <= cf_op * dl_op;
      if (mul_vld) begin
        acc <= acc + ACC_W'(prod);
      end
      // final state loads the output register itself
      if (res_valid && !res_stall && (state != ST_FINAL)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (smp_we) begin
            wp    <= wp_next;
            pos   <= wp_next;
            age   <= '0;
            acc   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          // one tap read per cycle, position walks backward from the newest sample
          pos <= (pos == '0) ? LAST_IDX : pos - 1'b1;
          if (age == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            age <= age + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld && !mul_vld) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            res_valid <= 1'b1;
            filtered  <= sat;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 61-tap Q15 direct-form FIR core. A table of
// directed transactions covers the rails, rounding, saturation, ignored
// tap indexes and unused fields. Random coefficient loads and sample runs
// follow. Every sample result is compared against a local bit-true filter
// model or a typed table value, with bursty request traffic and result-side backpressure.
// ----------------------------------------------------------------------------
module tb;
  import fir_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = TAPS + 12;
  localparam int N_DIRECTED   = 20;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] smp;
    logic [TAP_W-1:0]         tp;
    logic signed [DATA_W-1:0] cf;
    logic                     typed;
    logic signed [DATA_W-1:0] y;
  } fir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     req_valid   = 1'b0;
  logic                     req_stall;
  logic                     op          = OP_SAMPLE;
  logic signed [DATA_W-1:0] sample      = '0;
  logic [TAP_W-1:0]         tap         = '0;
  logic signed [DATA_W-1:0] coefficient = '0;
  logic                     res_valid;
  logic                     res_stall   = 1'b0;
  logic signed [DATA_W-1:0] filtered;

  // local filter state
  logic signed [DATA_W-1:0] model_hist [TAPS];
  logic signed [DATA_W-1:0] model_coef [TAPS];
  int                       model_pos;

  logic signed [DATA_W-1:0] expected_filtered [$];
  int                       error_count = 0;
  int                       cycle_count = 0;
  int                       burst_left  = 0;
  int                       stall_left  = 0;
  int                       free_left   = 0;

  // directed transactions; typed results are the obvious ones only
  fir_row_t directed_rows [N_DIRECTED] = '{
    // zero coefficients after reset, with junk in the unused fields
    '{OP_SAMPLE, 16'sh7FFF, 6'h3F, 16'sh7FFF, 1'b1, 16'sh0000},
    '{OP_SAMPLE, 16'sh8000, 6'h00, 16'sh8000, 1'b1, 16'sh0000},
    '{OP_COEF,   16'sh8000, 6'd0,  16'sh7FFF, 1'b0, 16'sh0000},
    // tap indexes past the end are dropped
    '{OP_COEF,   16'sh0000, 6'd63, 16'sh8000, 1'b0, 16'sh0000},
    '{OP_COEF,   16'sh7FFF, 6'd61, 16'sh1234, 1'b0, 16'sh0000},
    // single tap at the rails, rounding of half values
    '{OP_SAMPLE, 16'sh7FFF, 6'd0,  16'sh0000, 1'b1, 16'sh7FFE},
    '{OP_SAMPLE, 16'sh8000, 6'd0,  16'sh0000, 1'b1, 16'sh8001},
    '{OP_COEF,   16'sh0000, 6'd0,  16'sh8000, 1'b0, 16'sh0000},
    // positive overflow saturates
    '{OP_SAMPLE, 16'sh8000, 6'd0,  16'sh0000, 1'b1, 16'sh7FFF},
    '{OP_COEF,   16'sh0000, 6'd1,  16'sh8000, 1'b0, 16'sh0000},
    '{OP_SAMPLE, 16'sh7FFF, 6'd0,  16'sh0000, 1'b0, 16'sh0000},
    // negative overflow saturates
    '{OP_SAMPLE, 16'sh7FFF, 6'd0,  16'sh0000, 1'b1, 16'sh8000},
    '{OP_SAMPLE, 16'sh0000, 6'd0,  16'sh0000, 1'b0, 16'sh0000},
    // last valid tap
    '{OP_COEF,   16'sh5555, 6'd60, 16'sh7FFF, 1'b0, 16'sh0000},
    '{OP_COEF,   16'shAAAA, 6'd2,  16'sh0001, 1'b0, 16'sh0000},
    '{OP_SAMPLE, 16'sh0001, 6'h2A, 16'sh5555, 1'b0, 16'sh0000},
    '{OP_SAMPLE, 16'shFFFF, 6'h15, 16'shAAAA, 1'b0, 16'sh0000},
    '{OP_COEF,   16'sh0000, 6'd0,  16'sh0000, 1'b0, 16'sh0000},
    '{OP_COEF,   16'sh0000, 6'd1,  16'sh0000, 1'b0, 16'sh0000},
    '{OP_SAMPLE, 16'sh0000, 6'd0,  16'sh0000, 1'b0, 16'sh0000}
  };

  fir_filter_q15_circular_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .op          (op),
    .sample      (sample),
    .tap         (tap),
    .coefficient (coefficient),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .filtered    (filtered)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bit-true filter: returns 1 when the transaction gives a result
  function automatic logic predict_fir(input logic item_op,
                                       input logic signed [DATA_W-1:0] item_sample,
                                       input logic [TAP_W-1:0] item_tap,
                                       input logic signed [DATA_W-1:0] item_coef,
                                       output logic signed [DATA_W-1:0] y);
    longint acc;
    int     pos;
    y = '0;
    if (item_op == OP_COEF) begin
      if (int'(item_tap) < TAPS) model_coef[item_tap] = item_coef;
      return 1'b0;
    end
    model_pos = (model_pos + 1) % TAPS;
    model_hist[model_pos] = item_sample;
    acc = 0;
    pos = model_pos;
    // coefficient i pairs with the sample i transactions old
    for (int age = 0; age < TAPS; age++) begin
      acc += longint'(model_coef[age]) * longint'(model_hist[pos]);
      pos = (pos == 0) ? TAPS - 1 : pos - 1;
    end
    acc = (acc + longint'(ROUND_BIAS)) >>> FRAC_BITS;
    if (acc > longint'(SAT_MAX)) y = 16'sh7FFF;
    else if (acc < longint'(SAT_MIN)) y = 16'sh8000;
    else y = acc[DATA_W-1:0];
    return 1'b1;
  endfunction

  // random Q15 value from one of a few magnitude classes
  function automatic logic signed [DATA_W-1:0] random_q15(input int cls);
    case (cls)
      0: return DATA_W'($urandom);
      1: return DATA_W'($urandom_range(0, 4095) - 2048);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return '0;
    endcase
  endfunction

  // drive one transaction, wait for it to be taken, then maybe pause
  task automatic send_txn(input logic item_op, input logic signed [DATA_W-1:0] item_sample,
                          input logic [TAP_W-1:0] item_tap,
                          input logic signed [DATA_W-1:0] item_coef,
                          input logic typed, input logic signed [DATA_W-1:0] typed_y);
    logic signed [DATA_W-1:0] y;
    int                       gap;
    if (!req_valid) req_valid <= 1'b1;
    op          <= item_op;
    sample      <= item_sample;
    tap         <= item_tap;
    coefficient <= item_coef;
    do @(posedge clk); while (req_stall);
    if (predict_fir(item_op, item_sample, item_tap, item_coef, y))
      expected_filtered.push_back(typed ? typed_y : y);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // result side backpressure: quiet stretches, short hiccups, long holds
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (free_left != 0) begin
      free_left--;
    end else begin
      free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(0, 70);
      stall_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(10, 90);
    end
    res_stall <= (stall_left != 0);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_filtered.size() == 0) begin
        $error("unexpected transaction: filtered actual %0d", filtered);
        error_count++;
      end else begin
        if (filtered !== expected_filtered[0]) begin
          $error("filtered mismatch: expected %0d actual %0d", expected_filtered[0], filtered);
          error_count++;
        end
        void'(expected_filtered.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    int  items_done;
    int  count;
    int  cls;
    logic [TAP_W-1:0] tp;
    for (int i = 0; i < TAPS; i++) begin
      model_hist[i] = '0;
      model_coef[i] = '0;
    end
    model_pos  = 0;
    burst_left = $urandom_range(1, 12);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i])
      send_txn(directed_rows[i].op, directed_rows[i].smp, directed_rows[i].tp,
               directed_rows[i].cf, directed_rows[i].typed, directed_rows[i].y);

    // random coefficient loads interleaved with sample runs
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      cls = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) begin
        count = ($urandom_range(0, 7) == 0) ? TAPS : $urandom_range(1, 16);
        for (int k = 0; k < count; k++) begin
          tp = (count == TAPS) ? TAP_W'(k) : TAP_W'($urandom_range(0, TAPS - 1));
          // now and then an out-of-range index that the core drops
          if ($urandom_range(0, 9) == 0)
            send_txn(OP_COEF, DATA_W'($urandom), TAP_W'($urandom_range(TAPS, 63)),
                     DATA_W'($urandom), 1'b0, '0);
          send_txn(OP_COEF, DATA_W'($urandom), tp, random_q15(cls), 1'b0, '0);
          items_done++;
        end
      end else begin
        count = $urandom_range(5, 40);
        for (int k = 0; k < count; k++) begin
          send_txn(OP_SAMPLE, random_q15(cls), TAP_W'($urandom), DATA_W'($urandom),
                   1'b0, '0);
          items_done++;
        end
      end
    end
    if (req_valid) req_valid <= 1'b0;

    // drain
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
